### sv/smu_pkg.sv
// ----------------------------------------------------------------------------
// smu_pkg
// Shared types and constants for the sorted merge/union block: store depth,
// counter and address widths, command codes and the beat structs.
// ----------------------------------------------------------------------------
`default_nettype none

package smu_pkg;

  // capacity of each sequence store
  localparam int SEQ_DEPTH = 32;
  // counter holds 0..SEQ_DEPTH
  localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);
  // store address, at least one bit
  localparam int ADDR_W    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int DATA_W    = 32;

  // command codes carried in the kind field
  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_MERGE  = 2'd2;

  // input beat
  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic                     last;
    logic                     empty_res;
    logic                     overflow;
  } out_beat_t;

endpackage

`default_nettype wire

### sv/smu_ram.sv
// ----------------------------------------------------------------------------
// smu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/sorted_merge_union.sv
// ----------------------------------------------------------------------------
// sorted_merge_union
// Loads two ascending sequences A and B into bounded stores and, on a merge
// command, streams their merge in ascending order, dropping B elements equal
// to the current A head.
// ----------------------------------------------------------------------------
// Usage:
//   in_beat carries kind and value. Kind 0 appends value to A, kind 1 to B,
//   kind 2 starts a merge, kind 3 is ignored. A load into a full store is
//   dropped and raises the overflow flag carried on the next merge's results.
//   A merge walks both stores with one shared signed comparator; each
//   compare step is a store read followed by a compare, and an output
//   stall can hold a compare step. in_stall stays high for the whole merge.
//   One result is held back until the next one is known, so the final result
//   can carry last. A merge of two empty stores gives one result with
//   empty_res set. out_beat sits in an output register; when out_stall
//   is high the beat is held and the sequencer waits on its next emit.
//   After the final result the counts and overflow flag clear. Reset clears
//   counts, flag and handshake state; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_merge_union (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire smu_pkg::in_beat_t  in_beat,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output smu_pkg::out_beat_t      out_beat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FIN
  } state_t;

  state_t                              state_r, state_nxt;
  logic [smu_pkg::CNT_W-1:0]           cnt_a_r, cnt_a_nxt;
  logic [smu_pkg::CNT_W-1:0]           cnt_b_r, cnt_b_nxt;
  logic [smu_pkg::CNT_W-1:0]           idx_a_r, idx_a_nxt;
  logic [smu_pkg::CNT_W-1:0]           idx_b_r, idx_b_nxt;
  logic                                dropped_r, dropped_nxt;
  logic                                hold_valid_r, hold_valid_nxt;
  logic signed [smu_pkg::DATA_W-1:0]   hold_value_r, hold_value_nxt;
  logic                                out_valid_r, out_valid_nxt;
  smu_pkg::out_beat_t                  out_beat_r, out_beat_nxt;

  logic                                we_a, we_b;
  logic [smu_pkg::DATA_W-1:0]          rdata_a, rdata_b;
  logic                                a_ok, b_ok, out_free;
  logic                                take_a, take_b, emit;
  logic signed [smu_pkg::DATA_W-1:0]   emit_value;

  // sequence stores
  smu_ram #(
    .WIDTH (smu_pkg::DATA_W),
    .DEPTH (smu_pkg::SEQ_DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a_r[smu_pkg::ADDR_W-1:0]),
    .wdata (in_beat.value),
    .raddr (idx_a_r[smu_pkg::ADDR_W-1:0]),
    .rdata (rdata_a)
  );

  smu_ram #(
    .WIDTH (smu_pkg::DATA_W),
    .DEPTH (smu_pkg::SEQ_DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b_r[smu_pkg::ADDR_W-1:0]),
    .wdata (in_beat.value),
    .raddr (idx_b_r[smu_pkg::ADDR_W-1:0]),
    .rdata (rdata_b)
  );

  // heads remaining and output register status
  assign a_ok     = (idx_a_r < cnt_a_r);
  assign b_ok     = (idx_b_r < cnt_b_r);
  assign out_free = !out_valid_r || !out_stall;

  // shared signed compare picks the head to advance
  always_comb begin
    take_a     = 1'b0;
    take_b     = 1'b0;
    emit       = 1'b0;
    emit_value = $signed(rdata_a);
    if (a_ok && b_ok) begin
      if ($signed(rdata_a) < $signed(rdata_b)) begin
        take_a = 1'b1;
        emit   = 1'b1;
      end else if ($signed(rdata_b) < $signed(rdata_a)) begin
        take_b     = 1'b1;
        emit       = 1'b1;
        emit_value = $signed(rdata_b);
      end else begin
        // equal heads: drop the b element
        take_b = 1'b1;
      end
    end else if (a_ok) begin
      take_a = 1'b1;
      emit   = 1'b1;
    end else begin
      take_b     = 1'b1;
      emit       = 1'b1;
      emit_value = $signed(rdata_b);
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    cnt_a_nxt      = cnt_a_r;
    cnt_b_nxt      = cnt_b_r;
    idx_a_nxt      = idx_a_r;
    idx_b_nxt      = idx_b_r;
    dropped_nxt    = dropped_r;
    hold_valid_nxt = hold_valid_r;
    hold_value_nxt = hold_value_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_beat_nxt   = out_beat_r;
    we_a           = 1'b0;
    we_b           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_beat.kind)
            smu_pkg::KIND_LOAD_A: begin
              if (cnt_a_r < smu_pkg::CNT_W'(smu_pkg::SEQ_DEPTH)) begin
                we_a      = 1'b1;
                cnt_a_nxt = cnt_a_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            smu_pkg::KIND_LOAD_B: begin
              if (cnt_b_r < smu_pkg::CNT_W'(smu_pkg::SEQ_DEPTH)) begin
                we_b      = 1'b1;
                cnt_b_nxt = cnt_b_r + 1'b1;
              end else begin
                dropped_nxt = 1'b1;
              end
            end
            smu_pkg::KIND_MERGE: begin
              idx_a_nxt      = '0;
              idx_b_nxt      = '0;
              hold_valid_nxt = 1'b0;
              state_nxt      = ST_READ;
            end
            default: ;
          endcase
        end
      end

      // store read issued at the current heads
      ST_READ: begin
        if (!a_ok && !b_ok) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CMP;
        end
      end

      // compare step; a new result pushes the held one out
      ST_CMP: begin
        if (!(emit && hold_valid_r && !out_free)) begin
          if (emit) begin
            if (hold_valid_r) begin
              out_valid_nxt             = 1'b1;
              out_beat_nxt.result_value = hold_value_r;
              out_beat_nxt.last         = 1'b0;
              out_beat_nxt.empty_res    = 1'b0;
              out_beat_nxt.overflow     = dropped_r;
            end
            hold_valid_nxt = 1'b1;
            hold_value_nxt = emit_value;
          end
          if (take_a) begin
            idx_a_nxt = idx_a_r + 1'b1;
          end
          if (take_b) begin
            idx_b_nxt = idx_b_r + 1'b1;
          end
          state_nxt = ST_READ;
        end
      end

      // final beat, or the empty marker
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_beat_nxt.last      = 1'b1;
          out_beat_nxt.overflow  = dropped_r;
          out_beat_nxt.empty_res = !hold_valid_r;
          out_beat_nxt.result_value = hold_valid_r ? hold_value_r : '0;
          cnt_a_nxt      = '0;
          cnt_b_nxt      = '0;
          dropped_nxt    = 1'b0;
          hold_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      idx_a_r      <= '0;
      idx_b_r      <= '0;
      dropped_r    <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_a_r      <= cnt_a_nxt;
      cnt_b_r      <= cnt_b_nxt;
      idx_a_r      <= idx_a_nxt;
      idx_b_r      <= idx_b_nxt;
      dropped_r    <= dropped_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    hold_value_r <= hold_value_nxt;
    out_beat_r   <= out_beat_nxt;
  end

  // ports
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule

`default_nettype wire
